// ===== sv/wsd_pkg.sv =====
package wsd_pkg;

    localparam int WINDOW   = 8;
    localparam int SAMPLE_W = 24;
    localparam int TOL_W    = 24;
    localparam int ADDR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W   = $clog2(WINDOW + 1);

    localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(256);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_CMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic vld;
        logic first;
    } t_acc_ctl;

endpackage

// ===== sv/wsd_ring.sv =====
module wsd_ring (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [wsd_pkg::ADDR_W-1:0]           i_waddr,
    input  logic signed [wsd_pkg::SAMPLE_W-1:0]  i_wdata,
    input  logic                                 i_re,
    input  logic [wsd_pkg::ADDR_W-1:0]           i_raddr,
    output logic signed [wsd_pkg::SAMPLE_W-1:0]  o_rdata
);
    import wsd_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [WINDOW];
    logic signed [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/wsd_minmax.sv =====
module wsd_minmax (
    input  logic                                 i_clk,
    input  wsd_pkg::t_acc_ctl                    i_ctl,
    input  logic signed [wsd_pkg::SAMPLE_W-1:0]  i_data,
    output logic signed [wsd_pkg::SAMPLE_W-1:0]  o_min,
    output logic signed [wsd_pkg::SAMPLE_W-1:0]  o_max
);
    import wsd_pkg::*;

    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic signed [SAMPLE_W-1:0] n_min;
    logic signed [SAMPLE_W-1:0] n_max;

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (i_ctl.vld) begin
            if (i_ctl.first || (i_data < r_min)) begin
                n_min = i_data;
            end
            if (i_ctl.first || (i_data > r_max)) begin
                n_max = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_min <= n_min;
        r_max <= n_max;
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

// ===== sv/window_stability_detector.sv =====
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_func, i_sample
// result    out        o_valid / i_ready    o_stable
// config    in         i_tol_we             i_tol_wdata
//
// clear, or push that leaves the window short of full: IDLE, then EMIT, then result
// push that fills the window: IDLE, SCAN, DRAIN, CMP, EMIT, then result; the scan
// reads the ring through its single read port, one entry per cycle
// next item is taken while a finished result waits in the output register
// reset is synchronous, active low; ring contents are not cleared
module window_stability_detector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_func,
    input  logic signed [wsd_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_stable,
    input  logic                                 i_tol_we,
    input  logic [wsd_pkg::TOL_W-1:0]            i_tol_wdata
);
    import wsd_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [ADDR_W-1:0]   r_wp;
    logic [ADDR_W-1:0]   n_wp;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    logic [ADDR_W-1:0]   r_raddr;
    logic [ADDR_W-1:0]   n_raddr;
    t_acc_ctl            r_acc;
    t_acc_ctl            n_acc;
    logic [TOL_W-1:0]    r_tol;
    logic                r_res;
    logic                n_res;
    logic                r_o_valid;
    logic                n_o_valid;
    logic                r_o_stable;
    logic                n_o_stable;

    logic                in_xfer;
    logic                out_free;
    logic                push;
    logic                ram_re;
    logic [FILL_W-1:0]   fill_inc;
    logic signed [SAMPLE_W-1:0] rdata;
    logic signed [SAMPLE_W-1:0] win_min;
    logic signed [SAMPLE_W-1:0] win_max;
    logic [SAMPLE_W:0]   spread_ext;
    logic [SAMPLE_W-1:0] spread;

    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign push     = in_xfer && (i_func == FUNC_PUSH);
    assign fill_inc = (r_fill == FILL_FULL) ? r_fill : r_fill + FILL_W'(1);

    assign spread_ext = {win_max[SAMPLE_W-1], win_max} - {win_min[SAMPLE_W-1], win_min};
    assign spread     = spread_ext[SAMPLE_W-1:0];

    wsd_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_wp),
        .i_wdata (i_sample),
        .i_re    (ram_re),
        .i_raddr (r_raddr),
        .o_rdata (rdata)
    );

    wsd_minmax u_minmax (
        .i_clk  (i_clk),
        .i_ctl  (r_acc),
        .i_data (rdata),
        .o_min  (win_min),
        .o_max  (win_max)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if ((i_func == FUNC_PUSH) && (fill_inc == FILL_FULL)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                if (r_raddr == ADDR_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_CMP;
            S_CMP:   n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        o_ready    = 1'b0;
        ram_re     = 1'b0;
        n_wp       = r_wp;
        n_fill     = r_fill;
        n_raddr    = r_raddr;
        n_acc      = '0;
        n_res      = r_res;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_stable = r_o_stable;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                n_raddr = '0;
                n_res   = 1'b0;
                if (in_xfer) begin
                    if (i_func == FUNC_CLEAR) begin
                        n_wp   = '0;
                        n_fill = '0;
                    end else begin
                        n_wp   = (r_wp == ADDR_LAST) ? '0 : r_wp + ADDR_W'(1);
                        n_fill = fill_inc;
                    end
                end
            end
            S_SCAN: begin
                ram_re      = 1'b1;
                n_acc.vld   = 1'b1;
                n_acc.first = (r_raddr == '0);
                n_raddr     = r_raddr + ADDR_W'(1);
            end
            S_DRAIN: begin
            end
            S_CMP: begin
                n_res = (spread <= r_tol);
            end
            S_EMIT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_stable = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_fill    <= '0;
            r_acc     <= '0;
            r_tol     <= TOL_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_fill    <= n_fill;
            r_acc     <= n_acc;
            r_o_valid <= n_o_valid;
            if (i_tol_we) begin
                r_tol <= i_tol_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr    <= n_raddr;
        r_res      <= n_res;
        r_o_stable <= n_o_stable;
    end

    assign o_valid  = r_o_valid;
    assign o_stable = r_o_stable;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count above window size");

    a_scan_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_fill == FILL_FULL))
        else $error("scan started on a window that is not full");

    a_acc_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc.vld |-> ((r_state == S_SCAN) || (r_state == S_DRAIN)))
        else $error("accumulate outside scan");

    a_cmp_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_state == S_EMIT))
        else $error("compare not followed by emit");
`endif

endmodule

// ===== tb/tb_window_stability_detector.sv =====
module tb_window_stability_detector;
    import wsd_pkg::*;

    typedef struct {
        logic                       func;
        logic signed [SAMPLE_W-1:0] sample;
    } t_reading;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam longint S_MIN = longint'(SAMPLE_MIN);
    localparam longint S_MAX = longint'(SAMPLE_MAX);
    localparam int PHASE_ITEMS = 145;

    localparam int IDLE_SEND_LIGHT = 0;
    localparam int IDLE_SEND_HEAVY = 1;
    localparam int IDLE_NONE       = 2;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       i_func      = FUNC_PUSH;
    logic signed [SAMPLE_W-1:0] i_sample    = '0;
    logic                       i_ready     = 1'b0;
    logic                       i_tol_we    = 1'b0;
    logic [TOL_W-1:0]           i_tol_wdata = '0;
    logic                       o_ready;
    logic                       o_valid;
    logic                       o_stable;

    window_stability_detector u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_stable    (o_stable),
        .i_tol_we    (i_tol_we),
        .i_tol_wdata (i_tol_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_reading reading_q[$];
    bit       stable_q[$];

    int idle_mode = IDLE_SEND_LIGHT;
    int err_cnt   = 0;
    int n_pushes  = 0;
    int n_clears  = 0;
    int n_results = 0;
    int n_stable  = 0;
    int n_tol     = 0;

    // window tracking state
    logic signed [SAMPLE_W-1:0] ring_m [WINDOW];
    logic [ADDR_W-1:0]          wr_ptr_m = '0;
    int                         fill_m   = 0;
    logic [TOL_W-1:0]           tol_m    = TOL_RESET;

    function automatic bit window_step(t_reading r);
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0]        spread;
        if (r.func == FUNC_CLEAR) begin
            wr_ptr_m = '0;
            fill_m   = 0;
        end else begin
            ring_m[wr_ptr_m] = r.sample;
            wr_ptr_m = (wr_ptr_m == ADDR_LAST) ? '0 : wr_ptr_m + ADDR_W'(1);
            if (fill_m < WINDOW) fill_m++;
        end
        if (fill_m < WINDOW) return 1'b0;
        lo = ring_m[0];
        hi = ring_m[0];
        for (int i = 1; i < WINDOW; i++) begin
            if (ring_m[i] < lo) lo = ring_m[i];
            if (ring_m[i] > hi) hi = ring_m[i];
        end
        // true spread fits in the unsigned width, so modular subtract is exact
        spread = hi - lo;
        return spread <= tol_m;
    endfunction

    function automatic bit sender_idle();
        case (idle_mode)
            IDLE_SEND_LIGHT: return $urandom_range(0, 99) < 24;
            IDLE_SEND_HEAVY: return $urandom_range(0, 99) < 63;
            default:         return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idle();
        case (idle_mode)
            IDLE_SEND_LIGHT: return $urandom_range(0, 99) < 63;
            IDLE_SEND_HEAVY: return $urandom_range(0, 99) < 24;
            default:         return 1'b0;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clamp_sample(longint v);
        if (v < S_MIN) return SAMPLE_MIN;
        if (v > S_MAX) return SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t mismatch: %s", $time, what);
        err_cnt++;
    endtask

    // driver
    always @(posedge i_clk) begin : drive
        t_reading nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                nxt.func   = i_func;
                nxt.sample = i_sample;
                stable_q.push_back(window_step(nxt));
                if (i_func == FUNC_CLEAR) n_clears++;
                else n_pushes++;
            end
            if (!(i_valid && !o_ready)) begin
                if (reading_q.size() > 0 && !sender_idle()) begin
                    nxt = reading_q.pop_front();
                    i_func   <= nxt.func;
                    i_sample <= nxt.sample;
                    i_valid  <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch
        bit exp_stable;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_results++;
                if (stable_q.size() == 0) begin
                    report_mismatch($sformatf("result stable=%0b with nothing expected",
                                              o_stable));
                end else begin
                    exp_stable = stable_q.pop_front();
                    if (o_stable !== exp_stable)
                        report_mismatch($sformatf("stable got %b expected %0b",
                                                  o_stable, exp_stable));
                    else if (exp_stable)
                        n_stable++;
                end
            end
            i_ready <= !receiver_idle();
        end
    end

    task automatic queue_item(logic func, logic signed [SAMPLE_W-1:0] sample);
        t_reading r;
        r.func   = func;
        r.sample = sample;
        reading_q.push_back(r);
    endtask

    task automatic drain();
        while (reading_q.size() != 0 || i_valid || stable_q.size() != 0)
            @(negedge i_clk);
        repeat (WINDOW + 8) @(negedge i_clk);
    endtask

    task automatic set_tolerance(logic [TOL_W-1:0] v);
        @(posedge i_clk);
        i_tol_we    <= 1'b1;
        i_tol_wdata <= v;
        @(posedge i_clk);
        i_tol_we    <= 1'b0;
        tol_m = v;
        n_tol++;
        @(negedge i_clk);
    endtask

    // bursts of related samples so windows often sit near the tolerance edge
    task automatic fill_random(int count, logic [TOL_W-1:0] tol);
        int     left;
        int     kind;
        int     roll;
        longint base;
        longint room;
        longint v;
        t_reading r;
        left = 0;
        kind = 0;
        base = 0;
        repeat (count) begin
            if (left == 0) begin
                left = $urandom_range(8, 24);
                kind = $urandom_range(0, 9);
                room = (S_MAX - S_MIN) - (2 * longint'(tol) + 2);
                if (room < 0) room = 0;
                base = S_MIN + longint'($urandom_range(0, int'(room)));
            end
            left--;
            r.func   = FUNC_PUSH;
            r.sample = rand_sample();
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                r.func = FUNC_CLEAR;
            end else if (roll >= 7) begin
                case (kind)
                    0:       v = base;
                    1, 2:    v = base + longint'($urandom_range(0, int'(tol)));
                    3:       v = base + longint'($urandom_range(0, 2 * int'(tol) + 2));
                    4, 5:    v = base + ($urandom_range(0, 1) ? longint'(tol) : 0);
                    6, 7:    v = base + ($urandom_range(0, 1) ? longint'(tol) + 1 : 0);
                    8:       v = $urandom_range(0, 1) ? S_MIN : S_MAX;
                    default: v = longint'(r.sample);
                endcase
                r.sample = clamp_sample(v);
            end
            reading_q.push_back(r);
        end
    endtask

    task automatic run_phase(logic [TOL_W-1:0] tol, int mode);
        set_tolerance(tol);
        idle_mode = mode;
        fill_random(PHASE_ITEMS, tol);
        drain();
    endtask

    initial begin : main
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, at reset tolerance
        idle_mode = IDLE_SEND_LIGHT;
        queue_item(FUNC_CLEAR, SAMPLE_MAX);
        queue_item(FUNC_PUSH, SAMPLE_MIN);
        queue_item(FUNC_PUSH, SAMPLE_MAX);
        repeat (6) queue_item(FUNC_PUSH, '0);
        queue_item(FUNC_CLEAR, SAMPLE_MIN);
        repeat (7) queue_item(FUNC_PUSH, SAMPLE_W'(5));
        queue_item(FUNC_PUSH, SAMPLE_W'(5 + 256));
        queue_item(FUNC_PUSH, SAMPLE_W'(5 + 257));
        repeat (3) queue_item(FUNC_PUSH, SAMPLE_W'(6));
        queue_item(FUNC_CLEAR, '0);
        drain();

        run_phase('0, IDLE_SEND_LIGHT);
        run_phase('1, IDLE_SEND_LIGHT);
        run_phase(TOL_W'($urandom_range(1, 4095)), IDLE_SEND_HEAVY);
        run_phase(TOL_RESET, IDLE_SEND_HEAVY);
        run_phase(TOL_W'($urandom), IDLE_NONE);

        $display("covered %0d pushes and %0d clears across %0d tolerance settings,",
                 n_pushes, n_clears, n_tol + 1);
        $display("zero and full scale included; %0d results compared, %0d stable, %0d mismatches",
                 n_results, n_stable, err_cnt);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/wsd_pkg.sv
sv/wsd_ring.sv
sv/wsd_minmax.sv
sv/window_stability_detector.sv
tb/tb_window_stability_detector.sv
